// ===== design/rrw_pkg.sv =====
// Package for the receive reorder window: mode codes, configuration register
// indexes, the result record and the init unit status bundle.
// No dependencies.
`default_nettype none

package rrw_pkg;

  localparam int DEPTH = 64;
  localparam int SEQ_W = 32;
  localparam int PAYLOAD_W = 64;
  localparam int WIN_W = 7;
  localparam int MODE_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd64;

  typedef enum logic [MODE_W-1:0] {
    MODE_STORE   = 2'd0,
    MODE_DELIVER = 2'd1,
    MODE_SKIP    = 2'd2
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_START_SEQ = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b1;

  typedef struct packed {
    logic [SEQ_W-1:0] nack_seq;
    logic nack_needed;
    logic [PAYLOAD_W-1:0] out_payload;
    logic status;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } init_stat_t;

endpackage

`default_nettype wire

// ===== design/rrw_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rrw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/rrw_seq_mod.sv =====
// Reduction of a sequence number modulo DEPTH by multiplication with a fixed-point
// reciprocal, one multiply stage and one correction stage, then a registered done flag.
// Depends on rrw_pkg.
`default_nettype none

module rrw_seq_mod #(
  parameter int DEPTH = rrw_pkg::DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [rrw_pkg::SEQ_W-1:0]    value,
  output rrw_pkg::init_stat_t               stat,
  output logic      [$clog2(DEPTH)-1:0]     rem
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int SEQ_W = rrw_pkg::SEQ_W;
  localparam int RECIP_W = SEQ_W + 1;
  localparam int PROD_W = SEQ_W + RECIP_W;
  localparam int SHIFT = SEQ_W + IDX_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
  localparam logic [SEQ_W-1:0] DEPTH_S = SEQ_W'(DEPTH);

  logic [SEQ_W-1:0] value_q;
  logic [PROD_W-1:0] prod;
  logic [SEQ_W-1:0] quot;
  logic [SEQ_W-1:0] rest;
  logic mul_stage;
  logic sub_stage;
  logic done;

  // The reciprocal is rounded up with IDX_W extra fraction bits, which makes the
  // quotient exact for every 32-bit value.
  assign quot = SEQ_W'(prod[PROD_W-1:SHIFT]);
  assign rest = value_q - quot * DEPTH_S;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_stage <= 1'b0;
      sub_stage <= 1'b0;
      done <= 1'b0;
    end else begin
      mul_stage <= start;
      sub_stage <= mul_stage;
      done <= sub_stage;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      value_q <= value;
    end
    if (mul_stage) begin
      prod <= PROD_W'(value_q) * PROD_W'(RECIP);
    end
    if (sub_stage) begin
      rem <= rest[IDX_W-1:0];
    end
  end

  assign stat.busy = mul_stage | sub_stage | done;
  assign stat.done = done;

endmodule

`default_nettype wire

// ===== design/receive_reorder_window.sv =====
// Receive reorder window: one item may be accepted every cycle unless a register write is
// offered, a start number is being reduced or the output queue is full; each result is
// registered, then put in a three-entry output queue; input stalls once three results wait.
// Payloads sit in a registered-read RAM; slot valid bits are flip-flops.
// Reset empties the window at once with no clearing pass. A start_sequence write
// empties it too and then holds off input and register transfers while the slot index
// of the new start number is computed by reciprocal multiplication.
// Depends on rrw_pkg, rrw_ram and rrw_seq_mod.
`default_nettype none

module receive_reorder_window #(
  parameter int DEPTH = rrw_pkg::DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // seq [31:0], payload [95:32]
  input  wire logic [95:0]                       s_axis_tdata,
  // mode [1:0]
  input  wire logic [rrw_pkg::MODE_W-1:0]        s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // status [0], out_payload [64:1], nack_needed [65], nack_seq [97:66], zero [103:98]
  output logic      [103:0]                      m_axis_tdata,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rrw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rrw_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int SEQ_W = rrw_pkg::SEQ_W;
  localparam int PAY_W = rrw_pkg::PAYLOAD_W;
  localparam int WIN_W = rrw_pkg::WIN_W;
  localparam logic [IDX_W:0] DEPTH_X = (IDX_W + 1)'(DEPTH);
  localparam logic [SEQ_W-1:0] DEPTH_S = SEQ_W'(DEPTH);
  localparam int FIFO_DEPTH = 3;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [WIN_W-1:0] win_size;
  logic [SEQ_W-1:0] expected_seq;
  logic [IDX_W-1:0] eidx;
  logic [DEPTH-1:0] valid;

  logic [SEQ_W-1:0] in_seq;
  logic [PAY_W-1:0] in_payload;
  logic accept;
  logic cfg_accept;

  logic [SEQ_W-1:0] diff;
  logic [SEQ_W-1:0] win_ext;
  logic [SEQ_W-1:0] eff_win;
  logic in_win;
  logic wrap;
  logic [IDX_W:0] sum;
  logic [IDX_W:0] sum_red;
  logic [IDX_W-1:0] store_idx;
  logic [IDX_W-1:0] eidx_inc;

  logic [DEPTH-1:0] valid_next;
  logic [SEQ_W-1:0] expected_seq_next;
  logic [IDX_W-1:0] eidx_next;
  logic step_status;
  logic step_deliver;
  logic step_write;
  logic step_nack;

  rrw_pkg::init_stat_t init_stat;
  logic [IDX_W-1:0] init_rem;
  logic init_start;

  logic [PAY_W-1:0] ram_rdata;

  logic p_valid;
  logic p_status;
  logic p_deliver;
  logic p_nack;
  logic [SEQ_W-1:0] p_seq;

  rrw_pkg::result_t fifo [FIFO_DEPTH];
  rrw_pkg::result_t p_result;
  rrw_pkg::result_t head;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W:0] total;
  logic pop;

  assign in_seq = s_axis_tdata[SEQ_W-1:0];
  assign in_payload = s_axis_tdata[SEQ_W+PAY_W-1:SEQ_W];
  assign accept = s_axis_tvalid & s_axis_tready;
  assign cfg_ready = !init_stat.busy;
  assign cfg_accept = cfg_valid & cfg_ready;
  assign init_start = cfg_accept & (cfg_index == rrw_pkg::CFG_START_SEQ);

  // A store that wraps past zero lands below DEPTH, so its slot is the number itself.
  always_comb begin
    diff = in_seq - expected_seq;
    win_ext = {{(SEQ_W - WIN_W){1'b0}}, win_size};
    eff_win = (win_ext > DEPTH_S) ? DEPTH_S : win_ext;
    in_win = diff < eff_win;
    wrap = in_seq < expected_seq;
    sum = {1'b0, eidx} + {1'b0, diff[IDX_W-1:0]};
    sum_red = (sum >= DEPTH_X) ? sum - DEPTH_X : sum;
    store_idx = wrap ? in_seq[IDX_W-1:0] : sum_red[IDX_W-1:0];
    if (expected_seq == '1) begin
      eidx_inc = '0;
    end else begin
      eidx_inc = (({1'b0, eidx} + (IDX_W + 1)'(1)) == DEPTH_X) ? '0 : eidx + IDX_W'(1);
    end
  end

  always_comb begin
    valid_next = valid;
    expected_seq_next = expected_seq;
    eidx_next = eidx;
    step_status = 1'b0;
    step_deliver = 1'b0;
    step_write = 1'b0;
    case (s_axis_tuser)
      rrw_pkg::MODE_STORE: begin
        if (in_win) begin
          if (!valid[store_idx]) begin
            valid_next[store_idx] = 1'b1;
            step_write = 1'b1;
          end
        end else begin
          step_status = 1'b1;
        end
      end
      rrw_pkg::MODE_DELIVER: begin
        if (valid[eidx]) begin
          step_deliver = 1'b1;
          valid_next[eidx] = 1'b0;
          expected_seq_next = expected_seq + SEQ_W'(1);
          eidx_next = eidx_inc;
        end else begin
          step_status = 1'b1;
        end
      end
      rrw_pkg::MODE_SKIP: begin
        if (in_seq == expected_seq) begin
          valid_next[eidx] = 1'b0;
          expected_seq_next = expected_seq + SEQ_W'(1);
          eidx_next = eidx_inc;
        end
      end
      default: begin
        step_status = 1'b1;
      end
    endcase
    step_nack = !valid_next[eidx_next];
  end

  rrw_seq_mod #(
    .DEPTH(DEPTH)
  ) u_seq_mod (
    .clk(clk),
    .rst(rst),
    .start(init_start),
    .value(cfg_data[SEQ_W-1:0]),
    .stat(init_stat),
    .rem(init_rem)
  );

  rrw_ram #(
    .WIDTH(PAY_W),
    .DEPTH(DEPTH)
  ) u_payload_ram (
    .clk(clk),
    .we(accept & step_write),
    .waddr(store_idx),
    .wdata(in_payload),
    .re(accept & step_deliver),
    .raddr(eidx),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      win_size <= rrw_pkg::WINDOW_RESET;
      expected_seq <= '0;
      eidx <= '0;
      valid <= '0;
    end else if (cfg_accept) begin
      case (cfg_index)
        rrw_pkg::CFG_START_SEQ: begin
          expected_seq <= cfg_data[SEQ_W-1:0];
          valid <= '0;
        end
        rrw_pkg::CFG_WINDOW: begin
          win_size <= cfg_data[WIN_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (init_stat.done) begin
      eidx <= init_rem;
    end else if (accept) begin
      valid <= valid_next;
      expected_seq <= expected_seq_next;
      eidx <= eidx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_status <= step_status;
      p_deliver <= step_deliver;
      p_nack <= step_nack;
      p_seq <= expected_seq_next;
    end
  end

  always_comb begin
    p_result.status = p_status;
    p_result.out_payload = p_deliver ? ram_rdata : '0;
    p_result.nack_needed = p_nack;
    p_result.nack_seq = p_seq;
  end

  assign pop = m_axis_tvalid & m_axis_tready;
  assign total = {1'b0, count} + {{CNT_W{1'b0}}, p_valid};
  assign s_axis_tready = !init_stat.busy && !cfg_valid &&
                         (total < (CNT_W + 1)'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (p_valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(p_valid) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid) begin
      fifo[wr_ptr] <= p_result;
    end
  end

  assign head = fifo[rd_ptr];
  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata = {6'b0, head.nack_seq, head.nack_needed, head.out_payload, head.status};

endmodule

`default_nettype wire
